>>> rtl/psgri_pkg.sv
// shared types, constants and register mask table for the psg register interface
// no dependencies; used by psgri_core and psg_register_interface
package psgri_pkg;

    localparam int NUM_REGS     = 16;
    localparam int NUM_CHIPS_DEF = 2;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
    localparam logic [7:0] PORT_IN_VALUE = 8'hBF;
    localparam logic [4:0] CHIP_SEL_TAG  = 5'b11111;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_PORT_A    = 4'd14;
    localparam logic [3:0] REG_PORT_B    = 4'd15;

    typedef enum logic [1:0] {
        ACT_SELECT = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] attached_mask;
        logic       write_event;
        logic       write_chip;
        logic [3:0] write_reg;
        logic [7:0] write_value;
        logic       serial_strobe;
    } result_t;

    // implemented bits of each register
    function automatic logic [7:0] reg_mask(input logic [3:0] idx);
        logic [7:0] m;
        case (idx)
            4'd0:    m = 8'hFF;
            4'd1:    m = 8'h0F;
            4'd2:    m = 8'hFF;
            4'd3:    m = 8'h0F;
            4'd4:    m = 8'hFF;
            4'd5:    m = 8'h0F;
            4'd6:    m = 8'h1F;
            4'd7:    m = 8'hFF;
            4'd8:    m = 8'h1F;
            4'd9:    m = 8'h1F;
            4'd10:   m = 8'h1F;
            4'd11:   m = 8'hFF;
            4'd12:   m = 8'hFF;
            4'd13:   m = 8'h0F;
            4'd14:   m = 8'hFF;
            4'd15:   m = 8'hFF;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/psgri_core.sv
// register state of the chip pair and the single-pass access logic
// depends on psgri_pkg
module psgri_core #(
    parameter int NUM_CHIPS = psgri_pkg::NUM_CHIPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               dual_en,
    input  logic               fire,
    input  psgri_pkg::item_t   item,
    output psgri_pkg::result_t result
);

    localparam int Depth = NUM_CHIPS * psgri_pkg::NUM_REGS;
    localparam int AddrW = $clog2(Depth);

    logic [7:0] store_reg [Depth];
    logic [3:0] sel_reg   [NUM_CHIPS];
    // copy of bits 7:6 of register 7 per chip, so only one store read is needed
    logic [1:0] r7_reg    [NUM_CHIPS];
    logic       active_reg;

    logic             eff_chip;
    logic [3:0]       cur;
    logic [AddrW-1:0] addr;
    logic [7:0]       rd_byte;
    logic [7:0]       cur_mask;
    logic             chip_sel;

    assign eff_chip = (NUM_CHIPS > 1) && dual_en && active_reg;
    assign cur      = sel_reg[eff_chip];
    assign addr     = AddrW'({eff_chip, cur});
    assign rd_byte  = store_reg[addr];
    assign cur_mask = psgri_pkg::reg_mask(cur);
    assign chip_sel = dual_en && (item.data_byte[7:3] == psgri_pkg::CHIP_SEL_TAG);

    always_comb begin
        result               = '0;
        result.read_data     = psgri_pkg::BYTE_ALL_ONES;
        case (item.action)
            psgri_pkg::ACT_WRITE: begin
                result.write_event   = 1'b1;
                result.write_chip    = eff_chip;
                result.write_reg     = cur;
                result.write_value   = item.data_byte;
                result.serial_strobe = !eff_chip && (cur == psgri_pkg::REG_PORT_A);
            end
            psgri_pkg::ACT_READ: begin
                result.attached_mask = psgri_pkg::BYTE_ALL_ONES;
                if (cur == psgri_pkg::REG_PORT_A) begin
                    result.read_data = r7_reg[eff_chip][0] ?
                                       (psgri_pkg::PORT_IN_VALUE & rd_byte) :
                                       psgri_pkg::PORT_IN_VALUE;
                end else if (cur == psgri_pkg::REG_PORT_B && !r7_reg[eff_chip][1]) begin
                    result.read_data = psgri_pkg::BYTE_ALL_ONES;
                end else begin
                    result.read_data = rd_byte & cur_mask;
                end
            end
            default: begin
                result.read_data = psgri_pkg::BYTE_ALL_ONES;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Depth; i++) store_reg[i] <= '0;
            for (int c = 0; c < NUM_CHIPS; c++) begin
                sel_reg[c] <= '0;
                r7_reg[c]  <= '0;
            end
            active_reg <= 1'b0;
        end else if (fire) begin
            case (item.action)
                psgri_pkg::ACT_SELECT: begin
                    if (chip_sel) begin
                        active_reg <= item.data_byte[0];
                    end else begin
                        sel_reg[eff_chip] <= item.data_byte[3:0];
                    end
                end
                psgri_pkg::ACT_WRITE: begin
                    store_reg[addr] <= item.data_byte & cur_mask;
                    if (cur == psgri_pkg::REG_MIXER) begin
                        r7_reg[eff_chip] <= item.data_byte[7:6];
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/psg_register_interface.sv
// psg register interface top level: input register, access core, result register
// depends on psgri_pkg and psgri_core
//
// Bus-side register file of a two-chip sound generator.
// Input channel s_*: one bus access per transfer; s_tuser carries the access
// kind (select, data write, read) and s_tdata the bus byte.
// Result channel m_*: exactly one result transfer per access, in order, with
// the read data, bus drive mask and the write event for the tone generator.
// cfg_wr_en/cfg_wr_data set dual-chip mode; write only while no access is
// in flight.
// An accepted access waits in the input register until the result register can
// advance, then moves into the result register and m_tvalid rises; the result
// transfer follows once the receiver is ready.
// Throughput: one access per cycle while m_tready stays high; the register file
// is read and updated as an access moves from the input to the result register.
// Reset (aresetn low, synchronous) clears all registers, the register selects,
// the active chip and dual-chip mode, and empties both pipeline registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more access; after that s_tready stays low until m_tready.
module psg_register_interface #(
    parameter int NUM_CHIPS = psgri_pkg::NUM_CHIPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [15:8] attached_mask, [16] write_event, [17] write_chip,
    // [21:18] write_reg, [29:22] write_value, [30] serial_strobe, [31] zero
    output logic [31:0] m_tdata
);

    logic               dual_reg;
    logic               in_valid_reg;
    psgri_pkg::item_t   in_item_reg;
    logic               out_valid_reg;
    psgri_pkg::result_t out_res_reg;
    psgri_pkg::result_t res;
    logic               adv;
    logic               fire;

    assign adv      = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dual_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            dual_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action    <= psgri_pkg::action_t'(s_tuser);
            in_item_reg.data_byte <= s_tdata;
        end
    end

    psgri_core #(
        .NUM_CHIPS (NUM_CHIPS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .dual_en (dual_reg),
        .fire    (fire),
        .item    (in_item_reg),
        .result  (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.serial_strobe,
                       out_res_reg.write_value,
                       out_res_reg.write_reg,
                       out_res_reg.write_chip,
                       out_res_reg.write_event,
                       out_res_reg.attached_mask,
                       out_res_reg.read_data};

    // a data write that moves to the result stage always reports its event
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_item_reg.action == psgri_pkg::ACT_WRITE) |=> out_res_reg.write_event)
        else $error("data write lost its write event");

    // serial strobe only for chip 0 register 14 writes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.serial_strobe) |->
        (out_res_reg.write_event && !out_res_reg.write_chip &&
         out_res_reg.write_reg == psgri_pkg::REG_PORT_A))
        else $error("serial strobe without chip 0 register 14 write");

    // reads drive the bus and never report a write
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.attached_mask != 8'h00) |->
        (!out_res_reg.write_event && out_res_reg.attached_mask == psgri_pkg::BYTE_ALL_ONES))
        else $error("read result carries a write event");

    // a held input item stays put until it moves on
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("input stage dropped or changed a held access");

endmodule
